[rtl/rmst_pkg.sv]
// Shared types and constants for the range-minimum segment tree.
package rmst_pkg;

  localparam int DATA_W         = 32;
  localparam int IDX_W          = 17;    // holds an exclusive bound up to 65536
  localparam int LEAF_COUNT_DEF = 1024;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Work token handed from one tree level to the next one up.
  typedef struct packed {
    logic                     vld;
    logic                     qry;  // 1 query, 0 load
    logic [IDX_W-1:0]         l;    // load index, or query low bound
    logic [IDX_W-1:0]         r;    // query exclusive high bound
    logic signed [DATA_W-1:0] val;  // load value, or query accumulator
  } tok_t;

endpackage

[rtl/rmst_ram.sv]
// Generic RAM: one write port, two registered read ports.
module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/rmst_cell.sv]
// One tree level: node storage plus the update and query step for that level.
module rmst_cell #(
  parameter int LEVEL = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr_en,
  input  logic [rmst_pkg::IDX_W-1:0]   clr_addr,
  input  rmst_pkg::tok_t               tok_i,
  output rmst_pkg::tok_t               tok_o
);

  localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = rmst_pkg::DATA_W;

  logic [AW-1:0]   waddr, raddr_a, raddr_b;
  logic            we;
  logic [DW-1:0]   wdata, rdata_a, rdata_b;
  logic            take_l, take_r, active;
  logic [rmst_pkg::IDX_W-1:0] r_dec;

  rmst_pkg::tok_t  s1_r;
  logic            take_l_r, take_r_r;
  rmst_pkg::tok_t  tok_nxt;
  logic signed [DW-1:0] cand_l, cand_r, acc1;

  // Port selection: clear sweep wins, else load writes its node
  always_comb begin
    r_dec   = tok_i.r - 1'b1;
    active  = tok_i.vld && tok_i.qry && (tok_i.l < tok_i.r);
    take_l  = active && ((LEVEL == 0) ? 1'b1 : tok_i.l[0]);
    take_r  = active && (LEVEL != 0) && tok_i.r[0];
    we      = clr_en || (tok_i.vld && !tok_i.qry);
    waddr   = clr_en ? clr_addr[AW-1:0] : tok_i.l[AW-1:0];
    wdata   = clr_en ? rmst_pkg::INT_MAX : tok_i.val;
    // Query reads its own node, load reads the sibling
    raddr_a = tok_i.l[AW-1:0] ^ AW'(!tok_i.qry);
    raddr_b = r_dec[AW-1:0];
  end

  rmst_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Fold read data into the token and step the bounds to the parent level
  always_comb begin
    cand_l  = take_l_r ? $signed(rdata_a) : rmst_pkg::INT_MAX;
    cand_r  = take_r_r ? $signed(rdata_b) : rmst_pkg::INT_MAX;
    acc1    = (cand_l < s1_r.val) ? cand_l : s1_r.val;
    tok_nxt = s1_r;
    if (s1_r.qry) begin
      tok_nxt.val = (cand_r < acc1) ? cand_r : acc1;
      tok_nxt.l   = (s1_r.l + {{(rmst_pkg::IDX_W-1){1'b0}}, s1_r.l[0]}) >> 1;
      tok_nxt.r   = s1_r.r >> 1;
    end else begin
      if (LEVEL != 0 && $signed(rdata_a) < s1_r.val) begin
        tok_nxt.val = $signed(rdata_a);
      end
      tok_nxt.l = s1_r.l >> 1;
    end
  end

  // Advance the token through the two stages of this level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld  <= 1'b0;
      tok_o.vld <= 1'b0;
    end else begin
      s1_r.vld  <= tok_i.vld;
      tok_o.vld <= s1_r.vld;
    end
    s1_r.qry  <= tok_i.qry;
    s1_r.l    <= tok_i.l;
    s1_r.r    <= tok_i.r;
    s1_r.val  <= tok_i.val;
    take_l_r  <= take_l;
    take_r_r  <= take_r;
    tok_o.qry <= tok_nxt.qry;
    tok_o.l   <= tok_nxt.l;
    tok_o.r   <= tok_nxt.r;
    tok_o.val <= tok_nxt.val;
  end

endmodule

[rtl/range_minimum_segment_tree.sv]
// Top level of the range-minimum segment tree: command decode, clear sweep, level chain.
//
//  channel | dir | ports                          | contents
//  in_     | in  | in_tvalid/in_tready/in_tdata   | command, index, value, range
//  out_    | out | out_tvalid/out_tready/out_tdata| range minimum, queries only
//
// A load or query runs up a chain of one cell per tree level. One item is in
// the tree at a time. Clear, and reset, sweep all levels with in_tready low.
// A stalled result waits in the output register; a later query finishing
// meanwhile holds the tree until the output frees. LEAF_COUNT is a power
// of two.
module range_minimum_segment_tree #(
  parameter int LEAF_COUNT = rmst_pkg::LEAF_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] command, [11:2] element_index, [43:12] element_value,
  // [53:44] range_low, [63:54] range_high
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] range_minimum
  output logic [31:0] out_tdata
);

  localparam int IW   = rmst_pkg::IDX_W;
  localparam int LOG  = $clog2(LEAF_COUNT);
  localparam logic [IW-1:0] LEAF_N = IW'(LEAF_COUNT);

  typedef enum logic [1:0] {S_IDLE, S_CLEAR, S_RUN, S_HOLD} state_t;

  state_t              state_r;
  logic [IW-1:0]       clr_cnt_r;
  rmst_pkg::tok_t      tok [LOG+2];
  rmst_pkg::tok_t      inj_r;
  logic [31:0]         hold_r;
  logic                out_tvalid_r;
  logic [31:0]         out_tdata_r;

  logic [1:0]          cmd;
  logic [IW-1:0]       idx, lo, hi, hi_cut;
  logic signed [31:0]  value;
  logic                acc_in, out_free;
  logic                q_empty, inj_go, out_load;

  assign cmd    = in_tdata[1:0];
  assign idx    = IW'(in_tdata[11:2]);
  assign value  = $signed(in_tdata[43:12]);
  assign lo     = IW'(in_tdata[53:44]);
  assign hi     = IW'(in_tdata[63:54]);
  assign hi_cut = (hi >= LEAF_N) ? LEAF_N - 1'b1 : hi;

  assign in_tready  = (state_r == S_IDLE);
  assign acc_in     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign tok[0]     = inj_r;

  // Empty query range, and which commands start a token
  assign q_empty  = (lo > hi) || (lo >= LEAF_N);
  assign inj_go   = acc_in && ((cmd == rmst_pkg::CMD_LOAD && idx < LEAF_N) ||
                               cmd == rmst_pkg::CMD_QUERY);
  assign out_load = out_free && (state_r == S_HOLD ||
                    (state_r == S_RUN && tok[LOG+1].vld && tok[LOG+1].qry));

  // Chain of levels, leaves first, root last
  for (genvar g = 0; g <= LOG; g++) begin : g_lvl
    rmst_cell #(.LEVEL(LOG - g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr_en   (state_r == S_CLEAR),
      .clr_addr (clr_cnt_r),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

  // Decode commands, run the clear sweep, deliver results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      inj_r.vld    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      inj_r.vld <= inj_go;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            inj_r.l   <= (cmd == rmst_pkg::CMD_LOAD) ? idx : (q_empty ? '0 : lo);
            inj_r.val <= (cmd == rmst_pkg::CMD_LOAD) ? value : rmst_pkg::INT_MAX;
            inj_r.qry <= (cmd == rmst_pkg::CMD_QUERY);
            inj_r.r   <= (cmd == rmst_pkg::CMD_QUERY && q_empty) ? '0 : hi_cut + 1'b1;
            if (cmd == rmst_pkg::CMD_CLEAR) begin
              clr_cnt_r <= '0;
              state_r   <= S_CLEAR;
            end else if (inj_go) begin
              state_r   <= S_RUN;
            end
          end
        end
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LEAF_N - 1'b1) begin
            state_r <= S_IDLE;
          end
        end
        S_RUN: begin
          if (tok[LOG+1].vld) begin
            if (!tok[LOG+1].qry) begin
              state_r <= S_IDLE;
            end else if (out_free) begin
              out_tdata_r  <= tok[LOG+1].val;
              state_r      <= S_IDLE;
            end else begin
              hold_r  <= tok[LOG+1].val;
              state_r <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_tdata_r  <= hold_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // No token may leave the chain during a clear sweep
  a_no_tok_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !tok[LOG+1].vld)
    else $error("token left the chain during clear");

  // A token leaves the root only while an item is in flight
  a_tok_only_run: assert property (@(posedge clk) disable iff (!rst_n)
    tok[LOG+1].vld |-> state_r == S_RUN)
    else $error("token left the chain outside of run");

  // A new result appears only after a query finished
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_RUN || $past(state_r) == S_HOLD))
    else $error("result without a finished query");

  // Injection only follows an accepted transfer
  a_inject_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    inj_r.vld |-> $past(acc_in))
    else $error("token injected without a transfer");

endmodule

[tb/tb_top.sv]
// Testbench for the range-minimum segment tree: directed table, random commands, predicted results.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAVES = 1024;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         cmd;
    logic [9:0]         idx;
    logic signed [31:0] val;
    logic [9:0]         lo;
    logic [9:0]         hi;
    bit                 has_fixed;
    logic signed [31:0] fixed;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  logic signed [31:0] leaf_value [LEAVES];
  logic signed [31:0] minimum_queue [$];
  logic signed [31:0] fixed_queue [$];
  bit                 fixed_valid_queue [$];
  int errors = 0;
  int cycles = 0;
  int rx_wait = 0;
  bit hold_receiver = 1'b0;

  range_minimum_segment_tree #(.LEAF_COUNT(LEAVES)) dut (.*);

  // Run the clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run on a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // Reset and clear both leave every leaf at the largest value
  function automatic void clear_leaves();
    for (int i = 0; i < LEAVES; i++) leaf_value[i] = rmst_pkg::INT_MAX;
  endfunction

  // Minimum over the inclusive range, with the range end cut to the last leaf
  function automatic logic signed [31:0] range_min(int lo, int hi);
    logic signed [31:0] acc;
    acc = rmst_pkg::INT_MAX;
    if (lo > hi || lo >= LEAVES) return acc;
    if (hi >= LEAVES) hi = LEAVES - 1;
    for (int i = lo; i <= hi; i++) if (leaf_value[i] < acc) acc = leaf_value[i];
    return acc;
  endfunction

  // Drive one command and record what it will return
  task automatic send_step(input step_t s);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {s.hi, s.lo, s.val, s.idx, s.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (s.cmd)
      rmst_pkg::CMD_CLEAR: clear_leaves();
      rmst_pkg::CMD_LOAD: if (s.idx < LEAVES) leaf_value[s.idx] = s.val;
      rmst_pkg::CMD_QUERY: begin
        minimum_queue.push_back(range_min(s.lo, s.hi));
        fixed_valid_queue.push_back(s.has_fixed);
        fixed_queue.push_back(s.fixed);
      end
      default: ;
    endcase
  endtask

  function automatic step_t mk(logic [1:0] c, int i, logic signed [31:0] v, int l, int h,
                               bit f = 0, logic signed [31:0] fv = 0);
    step_t s;
    s.cmd = c; s.idx = 10'(i); s.val = v; s.lo = 10'(l); s.hi = 10'(h);
    s.has_fixed = f; s.fixed = fv;
    return s;
  endfunction

  function automatic step_t random_step();
    step_t s;
    int r, a, b;
    r = $urandom_range(0, 99);
    a = $urandom_range(0, 15) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 63);
    b = $urandom_range(0, 15) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 63);
    if (r < 2) s = mk(rmst_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    else if (r < 4) s = mk(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
    else if (r < 50) s = mk(rmst_pkg::CMD_LOAD, a, $urandom, $urandom, $urandom);
    else if (r < 90) s = mk(rmst_pkg::CMD_QUERY, $urandom, $urandom, a < b ? a : b,
                            a < b ? b : a);
    else s = mk(rmst_pkg::CMD_QUERY, $urandom, $urandom, $urandom, $urandom);
    return s;
  endfunction

  // Receiver: draw a wait after each result, and hold off while requested
  always @(posedge clk) begin
    int w;
    if (out_tvalid && out_tready) begin
      w = $urandom_range(0, 16);
      rx_wait <= w;
      out_tready <= (w == 0) && !hold_receiver;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_receiver;
    end
  end

  // Compare each result transfer against the oldest expected minimum
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (minimum_queue.size() == 0) begin
        report_mismatch("unexpected result");
      end else begin
        logic signed [31:0] want;
        bit fv;
        logic signed [31:0] fx;
        want = minimum_queue.pop_front();
        fv = fixed_valid_queue.pop_front();
        fx = fixed_queue.pop_front();
        if ($signed(out_tdata) !== want)
          report_mismatch($sformatf("range_minimum got %0d want %0d", $signed(out_tdata), want));
        else if (fv && want !== fx)
          report_mismatch($sformatf("predictor gives %0d, table says %0d", want, fx));
      end
    end
  end

  initial begin
    step_t table_steps [$];
    clear_leaves();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, every command, special cases
    table_steps = '{
      mk(rmst_pkg::CMD_QUERY, 0, 0, 0, 1023, 1, rmst_pkg::INT_MAX),
      mk(rmst_pkg::CMD_LOAD, 0, 32'sh8000_0000, 0, 0),
      mk(rmst_pkg::CMD_LOAD, 1023, 32'sh7FFF_FFFE, 0, 0),
      mk(rmst_pkg::CMD_LOAD, 512, -1, 0, 0),
      mk(rmst_pkg::CMD_LOAD, 341, 32'sh5555_5555, 0, 0),
      mk(rmst_pkg::CMD_LOAD, 682, 32'shAAAA_AAAA, 0, 0),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 0, 1023, 1, 32'sh8000_0000),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 0, 0, 1, 32'sh8000_0000),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 1023, 1023, 1, 32'sh7FFF_FFFE),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 1, 1022),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 5, 4, 1, rmst_pkg::INT_MAX),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 1023, 0, 1, rmst_pkg::INT_MAX),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 2, 3, 1, rmst_pkg::INT_MAX),
      mk(CMD_UNUSED, 1023, 32'sh8000_0000, 1023, 1023),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 513, 1023),
      mk(rmst_pkg::CMD_CLEAR, 1023, -1, 1023, 1023),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 0, 1023, 1, rmst_pkg::INT_MAX),
      mk(rmst_pkg::CMD_LOAD, 7, 0, 0, 0),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 7, 7, 1, 0),
      mk(rmst_pkg::CMD_QUERY, 0, 0, 6, 8, 1, 0)
    };
    foreach (table_steps[k]) send_step(table_steps[k]);

    // Random commands; hold the receiver off once and drain once midway
    for (int n = 0; n < 550; n++) begin
      if (n == 150) begin
        fork
          begin
            hold_receiver = 1'b1;
            repeat (400) @(posedge clk);
            hold_receiver = 1'b0;
          end
        join_none
      end
      if (n == 300) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (minimum_queue.size() != 0) @(posedge clk);
      end
      send_step(random_step());
    end

    in_tvalid <= 1'b0;
    while (minimum_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

[sim.f]
rtl/rmst_pkg.sv
rtl/rmst_ram.sv
rtl/rmst_cell.sv
rtl/range_minimum_segment_tree.sv
tb/tb_top.sv
